// ===== design/clns_pkg.sv =====
// Shared types, codes and small tables for the character LCD nibble bus sequencer.
// No dependencies; every other design file refers to this package by scoped names.
package clns_pkg;

    // request op codes
    localparam logic [2:0] OP_CMD    = 3'd0;
    localparam logic [2:0] OP_DATA   = 3'd1;
    localparam logic [2:0] OP_CURSOR = 3'd2;
    localparam logic [2:0] OP_DEC    = 3'd3;
    localparam logic [2:0] OP_HEX    = 3'd4;
    localparam logic [2:0] OP_INIT   = 3'd5;

    // bus word bits
    localparam logic [7:0] BUS_RESET = 8'hC0;
    localparam int         BIT_RS    = 6;
    localparam int         BIT_RW    = 5;
    localparam int         BIT_EN    = 4;

    // cursor row bases
    localparam logic [7:0] ROW0_BASE = 8'h80;
    localparam logic [7:0] ROW1_BASE = 8'hC0;

    // long waits after init bytes
    localparam logic [1:0] WAITS_NONE  = 2'd0;
    localparam logic [1:0] WAITS_INIT  = 2'd1;
    localparam logic [1:0] WAITS_CLEAR = 2'd2;

    // byte queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_RUN  = 2'b10
    } fstate_t;

    // one byte to be framed onto the bus
    typedef struct packed {
        logic [7:0] data;
        logic       is_cmd;
        logic [1:0] waits;
        logic       last;
    } qent_t;

    function automatic logic [7:0] init_cmd(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0:    r = 8'h33;
            3'd1:    r = 8'h32;
            3'd2:    r = 8'h28;
            3'd3:    r = 8'h0C;
            3'd4:    r = 8'h06;
            3'd5:    r = 8'h01;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // lowercase hex character
    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10)
            r = 8'h30 + {4'h0, d};
        else
            r = 8'h57 + {4'h0, d};
        return r;
    endfunction

    // digit weight for decimal step idx
    function automatic logic [16:0] pow10(input logic [2:0] idx);
        logic [16:0] r;
        case (idx)
            3'd0:    r = 17'd10000;
            3'd1:    r = 17'd1000;
            3'd2:    r = 17'd100;
            3'd3:    r = 17'd10;
            default: r = 17'd1;
        endcase
        return r;
    endfunction

    // index of final byte step for each op
    function automatic logic [2:0] last_idx(input logic [2:0] op);
        logic [2:0] r;
        case (op)
            OP_DEC:  r = 3'd4;
            OP_HEX:  r = 3'd1;
            OP_INIT: r = 3'd5;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/char_lcd_nibble_bus_sequencer_top.sv =====
// Top level of the character LCD nibble bus sequencer.
// Depends on clns_pkg, clns_front, clns_queue and clns_back.
//
//  Channel   Direction  Handshake              Payload
//  request   in         req_valid / req_stall  op, value, col, row
//  word      out        word_valid/word_stall  bus_word, settle_before,
//                                              long_waits_after, last
//
// Words: the back end emits one bus word per cycle unless a word stall holds
//   it, eight per byte; a request gives one byte (command, data, cursor), two
//   (hex), four or five (decimal) or six (init); the back end sets the rate.
// The front end accepts a request, then walks its byte list (one
//   decimal digit per step); the request stall is high while it walks the list.
//   Op codes six and seven are accepted and produce no words.
// Reset: bus word returns to 0xC0 (RS and backlight set), queue empties.
// A word stall freezes the back end; the front end keeps filling the 4-entry
//   byte queue, then stalls on its own.
module char_lcd_nibble_bus_sequencer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [2:0]  op,
    input  logic [15:0] value,
    input  logic [3:0]  col,
    input  logic [0:0]  row,
    output logic        word_valid,
    input  logic        word_stall,
    output logic [7:0]  bus_word,
    output logic        settle_before,
    output logic [1:0]  long_waits_after,
    output logic        last
);

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    clns_pkg::qent_t q_in;
    clns_pkg::qent_t q_head;

    // request decode and byte list walk
    clns_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .op        (op),
        .value     (value),
        .col       (col),
        .row       (row),
        .q_full    (q_full),
        .push      (q_push),
        .push_ent  (q_in)
    );

    // byte queue
    clns_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_ent (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    // nibble framing onto the bus
    clns_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_head           (q_head),
        .pop              (q_pop),
        .word_valid       (word_valid),
        .word_stall       (word_stall),
        .bus_word         (bus_word),
        .settle_before    (settle_before),
        .long_waits_after (long_waits_after),
        .last             (last)
    );

endmodule

// ===== design/clns_front.sv =====
// Front end: takes requests, classifies them and walks each through its byte list.
// Depends on clns_pkg; pushes at most one byte entry per cycle into clns_queue while it is not full.
module clns_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [2:0]         op,
    input  logic [15:0]        value,
    input  logic [3:0]         col,
    input  logic [0:0]         row,
    input  logic               q_full,
    output logic               push,
    output clns_pkg::qent_t    push_ent
);

    clns_pkg::fstate_t state_reg, state_next;
    logic [2:0]  idx_reg, idx_next;
    logic [2:0]  op_reg;
    logic [15:0] val_reg;
    logic [3:0]  col_reg;
    logic        row_reg;

    logic        accept;
    logic        step;
    logic        at_last;
    logic [3:0]  dig;
    logic [16:0] sub;
    logic [16:0] thr;
    logic [16:0] wt;
    logic [16:0] rem;
    logic [7:0]  base;
    logic [7:0]  byte_sel;

    assign req_stall = (state_reg != clns_pkg::F_IDLE);
    assign accept    = req_valid && (state_reg == clns_pkg::F_IDLE);
    assign step      = (state_reg == clns_pkg::F_RUN) && !q_full;
    assign at_last   = (idx_reg == clns_pkg::last_idx(op_reg));

    // one decimal digit per step: parallel compares against k * weight
    always_comb
    begin
        wt  = clns_pkg::pow10(idx_reg);
        dig = 4'd0;
        sub = 17'd0;
        thr = 17'd0;
        for (int k = 1; k <= 9; k++)
        begin
            thr = 17'(k) * wt;
            if ({1'b0, val_reg} >= thr)
            begin
                dig = 4'(k);
                sub = thr;
            end
        end
        rem = {1'b0, val_reg} - sub;
    end

    assign base = row_reg ? clns_pkg::ROW1_BASE : clns_pkg::ROW0_BASE;

    always_comb
    begin
        case (op_reg)
            clns_pkg::OP_CMD,
            clns_pkg::OP_DATA:   byte_sel = val_reg[7:0];
            clns_pkg::OP_CURSOR: byte_sel = base + {4'h0, col_reg};
            clns_pkg::OP_DEC:    byte_sel = 8'h30 | {4'h0, dig};
            clns_pkg::OP_HEX:    byte_sel = clns_pkg::hex_char(
                                     (idx_reg == 3'd0) ? val_reg[7:4] : val_reg[3:0]);
            clns_pkg::OP_INIT:   byte_sel = clns_pkg::init_cmd(idx_reg);
            default:             byte_sel = 8'h00;
        endcase
    end

    always_comb
    begin
        push_ent.data   = byte_sel;
        push_ent.is_cmd = op_reg inside {clns_pkg::OP_CMD, clns_pkg::OP_CURSOR,
                                         clns_pkg::OP_INIT};
        if (op_reg == clns_pkg::OP_INIT)
            push_ent.waits = (idx_reg == 3'd5) ? clns_pkg::WAITS_CLEAR
                                               : clns_pkg::WAITS_INIT;
        else
            push_ent.waits = clns_pkg::WAITS_NONE;
        push_ent.last   = at_last;
    end

    // leading ten-thousands zero is dropped
    assign push = step && !((op_reg == clns_pkg::OP_DEC) && (idx_reg == 3'd0)
                            && (dig == 4'd0));

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            clns_pkg::F_IDLE:
            begin
                idx_next = 3'd0;
                if (accept && (op <= clns_pkg::OP_INIT))
                    state_next = clns_pkg::F_RUN;
            end
            clns_pkg::F_RUN:
            begin
                if (step)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (at_last)
                        state_next = clns_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = clns_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= clns_pkg::F_IDLE;
            idx_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op;
            val_reg <= value;
            col_reg <= col;
            row_reg <= row[0];
        end
        else if (step && (op_reg == clns_pkg::OP_DEC))
        begin
            val_reg <= rem[15:0];
        end
    end

endmodule

// ===== design/clns_queue.sv =====
// Short byte queue decoupling the request front end from the bus word back end.
// Depends on clns_pkg for the entry type and depth.
module clns_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  clns_pkg::qent_t push_ent,
    output logic            full,
    input  logic            pop,
    output clns_pkg::qent_t head,
    output logic            empty
);

    clns_pkg::qent_t mem [clns_pkg::Q_DEPTH];
    logic [clns_pkg::Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [clns_pkg::Q_AW:0]   count_reg, count_next;
    logic do_push, do_pop;

    assign full    = (count_reg == (clns_pkg::Q_AW+1)'(clns_pkg::Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_ent;
    end

endmodule

// ===== design/clns_back.sv =====
// Back end: frames each queued byte as eight nibble bus words, one per cycle unless a word stall holds it.
// Depends on clns_pkg; holds the live bus word and the output register.
module clns_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  clns_pkg::qent_t q_head,
    output logic            pop,
    output logic            word_valid,
    input  logic            word_stall,
    output logic [7:0]      bus_word,
    output logic            settle_before,
    output logic [1:0]      long_waits_after,
    output logic            last
);

    logic            active_reg, active_next;
    logic [2:0]      phase_reg;
    logic [2:0]      phase;
    clns_pkg::qent_t ent_reg;
    clns_pkg::qent_t ent;
    logic [7:0]      bus_word_reg, bus_word_next;
    logic            valid_reg;
    logic            settle_reg, settle_next;
    logic [1:0]      waits_reg, waits_next;
    logic            last_reg, last_next;
    logic            advance;
    logic            go;

    assign advance = !valid_reg || !word_stall;
    assign go      = advance && (active_reg || !q_empty);
    assign pop     = go && !active_reg;
    assign ent     = active_reg ? ent_reg : q_head;
    assign phase   = active_reg ? phase_reg : 3'd0;

    always_comb
    begin
        bus_word_next = bus_word_reg;
        settle_next   = 1'b1;
        waits_next    = clns_pkg::WAITS_NONE;
        last_next     = 1'b0;
        case (phase)
            3'd0:
            begin
                bus_word_next[clns_pkg::BIT_EN] = 1'b0;
                bus_word_next[clns_pkg::BIT_RW] = 1'b0;
            end
            3'd1:
            begin
                bus_word_next[clns_pkg::BIT_RS] = !ent.is_cmd;
                settle_next = 1'b0;
            end
            3'd2:    bus_word_next[3:0] = ent.data[7:4];
            3'd3:    bus_word_next[clns_pkg::BIT_EN] = 1'b1;
            3'd4:    bus_word_next[clns_pkg::BIT_EN] = 1'b0;
            3'd5:    bus_word_next[3:0] = ent.data[3:0];
            3'd6:    bus_word_next[clns_pkg::BIT_EN] = 1'b1;
            3'd7:
            begin
                bus_word_next[clns_pkg::BIT_EN] = 1'b0;
                waits_next = ent.waits;
                last_next  = ent.last;
            end
            default: bus_word_next = bus_word_reg;
        endcase
    end

    always_comb
    begin
        active_next = active_reg;
        if (go)
            active_next = (phase != 3'd7);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            phase_reg    <= 3'd0;
            valid_reg    <= 1'b0;
            bus_word_reg <= clns_pkg::BUS_RESET;
        end
        else
        begin
            active_reg <= active_next;
            if (go)
            begin
                phase_reg    <= phase + 3'd1;
                bus_word_reg <= bus_word_next;
                valid_reg    <= 1'b1;
            end
            else if (advance)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            ent_reg <= q_head;
        if (go)
        begin
            settle_reg <= settle_next;
            waits_reg  <= waits_next;
            last_reg   <= last_next;
        end
    end

    assign word_valid       = valid_reg;
    assign bus_word         = bus_word_reg;
    assign settle_before    = settle_reg;
    assign long_waits_after = waits_reg;
    assign last             = last_reg;

endmodule
